/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL files of the ellipse span generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property at every rising edge while out of reset.
`define ASSERT_AT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("%m: check failed");
// Check that a condition never holds while out of reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("%m: forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

/* hdl/efsg_pkg.sv */
// Shared types and constants of the ellipse fill span generator.
`default_nettype none
package efsg_pkg;

	// Field widths of the command and span words.
	localparam int CX_W    = 15;
	localparam int HW_W    = 10;
	localparam int HH_W    = 5;
	localparam int COLOR_W = 32;
	localparam int COORD_W = 16;

	// Datapath widths of the slope search.
	localparam int X_W      = HW_W + 1;       // search column, up to twice the radius
	localparam int START_W  = X_W + 1;        // signed search start
	localparam int SQ_W     = 2 * X_W;        // x squared
	localparam int HSQ_W    = 2 * HH_W;       // h squared
	localparam int WSQ_W    = 2 * HW_W;       // w squared
	localparam int HHWW_W   = HSQ_W + WSQ_W;  // h squared times w squared
	localparam int YSQ_W    = 2 * HH_W;       // y squared
	localparam int YTERM_W  = YSQ_W + WSQ_W;  // y squared times w squared
	localparam int P_W      = SQ_W + HSQ_W;   // x squared times h squared
	localparam int D_W      = START_W + HSQ_W; // (2x - 1) times h squared

	// Command queue between the front end and the span engine.
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// Fill command as it arrives on the input channel.
	typedef struct packed {
		logic [COLOR_W-1:0]     color;
		logic [HH_W-1:0]        h;
		logic [HW_W-1:0]        w;
		logic signed [CX_W-1:0] cy;
		logic signed [CX_W-1:0] cx;
	} req_t;

	// Command after radius clamping, with its constant products.
	typedef struct packed {
		logic [HHWW_W-1:0]      hhww;
		logic [WSQ_W-1:0]       ww;
		logic [HSQ_W-1:0]       hh;
		logic [COLOR_W-1:0]     color;
		logic [HH_W-1:0]        h;
		logic [HW_W-1:0]        w;
		logic signed [CX_W-1:0] cy;
		logic signed [CX_W-1:0] cx;
	} cmd_t;

	// One span word on the output channel.
	typedef struct packed {
		logic                      last;
		logic [COLOR_W-1:0]        color;
		logic signed [COORD_W-1:0] right;
		logic signed [COORD_W-1:0] left;
		logic signed [COORD_W-1:0] row;
	} span_t;

	// Span engine sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIAM,
		ST_START,
		ST_SQUARE,
		ST_PRODUCT,
		ST_SEARCH,
		ST_UPPER,
		ST_LOWER
	} state_t;

endpackage
`default_nettype wire

/* hdl/efsg_front.sv */
// Command front end: accepts fill commands, clamps radii and forms constant products.
`default_nettype none
module efsg_front #(
	parameter int MAX_HALF_WIDTH  = 1023,
	parameter int MAX_HALF_HEIGHT = 31
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire efsg_pkg::req_t req,
	output logic               push_valid,
	input  wire logic          push_ready,
	output efsg_pkg::cmd_t     push_data
);

	logic                          valid_s1;
	logic                          valid_s2;
	logic                          ready_s1;
	logic                          ready_s2;
	efsg_pkg::cmd_t                cmd_s1;
	efsg_pkg::cmd_t                cmd_s2;
	logic [efsg_pkg::HW_W-1:0]     w_sat;
	logic [efsg_pkg::HH_W-1:0]     h_sat;

	// A stage moves when it is empty or the stage after it moves.
	always_comb begin
		ready_s2  = !valid_s2 || push_ready;
		ready_s1  = !valid_s1 || ready_s2;
		req_ready = ready_s1;
	end

	// Radii above the supported limits saturate.
	always_comb begin
		if (32'(req.w) > MAX_HALF_WIDTH) begin
			w_sat = efsg_pkg::HW_W'(MAX_HALF_WIDTH);
		end else begin
			w_sat = req.w;
		end
		if (32'(req.h) > MAX_HALF_HEIGHT) begin
			h_sat = efsg_pkg::HH_W'(MAX_HALF_HEIGHT);
		end else begin
			h_sat = req.h;
		end
	end

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= req_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// First stage squares the radii, second stage multiplies the squares.
	always_ff @(posedge clk) begin
		if (ready_s1 && req_valid) begin
			cmd_s1.cx    <= req.cx;
			cmd_s1.cy    <= req.cy;
			cmd_s1.w     <= w_sat;
			cmd_s1.h     <= h_sat;
			cmd_s1.color <= req.color;
			cmd_s1.hh    <= efsg_pkg::HSQ_W'(h_sat) * efsg_pkg::HSQ_W'(h_sat);
			cmd_s1.ww    <= efsg_pkg::WSQ_W'(w_sat) * efsg_pkg::WSQ_W'(w_sat);
			cmd_s1.hhww  <= '0;
		end
		if (ready_s2 && valid_s1) begin
			cmd_s2.cx    <= cmd_s1.cx;
			cmd_s2.cy    <= cmd_s1.cy;
			cmd_s2.w     <= cmd_s1.w;
			cmd_s2.h     <= cmd_s1.h;
			cmd_s2.color <= cmd_s1.color;
			cmd_s2.hh    <= cmd_s1.hh;
			cmd_s2.ww    <= cmd_s1.ww;
			cmd_s2.hhww  <= efsg_pkg::HHWW_W'(cmd_s1.hh) * efsg_pkg::HHWW_W'(cmd_s1.ww);
		end
	end

	assign push_valid = valid_s2;
	assign push_data  = cmd_s2;

endmodule
`default_nettype wire

/* hdl/efsg_queue.sv */
// Short command queue between the front end and the span engine.
`default_nettype none
`include "assert_macros.svh"
module efsg_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push_valid,
	output logic                push_ready,
	input  wire efsg_pkg::cmd_t push_data,
	output logic                pop_valid,
	input  wire logic           pop_ready,
	output efsg_pkg::cmd_t      pop_data
);

	efsg_pkg::cmd_t                    entry_q [efsg_pkg::QUEUE_DEPTH];
	logic [efsg_pkg::QUEUE_AW-1:0]     wr_ptr_q;
	logic [efsg_pkg::QUEUE_AW-1:0]     rd_ptr_q;
	logic [efsg_pkg::QUEUE_AW:0]       count_q;
	logic                              push;
	logic                              pop;

	// Handshakes on both sides.
	always_comb begin
		push_ready = count_q != (efsg_pkg::QUEUE_AW+1)'(efsg_pkg::QUEUE_DEPTH);
		pop_valid  = count_q != '0;
		push       = push_valid && push_ready;
		pop        = pop_valid && pop_ready;
		pop_data   = entry_q[rd_ptr_q];
	end

	// Pointers wrap at the queue depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				if (32'(wr_ptr_q) == efsg_pkg::QUEUE_DEPTH - 1) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + 1'b1;
				end
			end
			if (pop) begin
				if (32'(rd_ptr_q) == efsg_pkg::QUEUE_DEPTH - 1) begin
					rd_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
				end
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	`ASSERT_NEVER(a_count_range, clk, arst_n, 32'(count_q) > efsg_pkg::QUEUE_DEPTH)
	`ASSERT_NEVER(a_ptr_match, clk, arst_n, (count_q == '0) && (wr_ptr_q != rd_ptr_q))
	`ASSERT_AT(a_head_holds, clk, arst_n, (pop_valid && !pop_ready) |=> $stable(pop_data))

endmodule
`default_nettype wire

/* hdl/efsg_engine.sv */
// Span engine: slope search per row and span emission through an output register.
`default_nettype none
`include "assert_macros.svh"
module efsg_engine (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cmd_valid,
	output logic                cmd_ready,
	input  wire efsg_pkg::cmd_t cmd,
	output logic                span_valid,
	input  wire logic           span_ready,
	output efsg_pkg::span_t     span
);

	efsg_pkg::state_t                      state_q;
	efsg_pkg::state_t                      state_d;
	efsg_pkg::cmd_t                        cmd_q;
	logic [efsg_pkg::HH_W-1:0]             y_q;
	logic [efsg_pkg::HW_W-1:0]             cur_x_q;
	logic [efsg_pkg::HW_W-1:0]             prev_x_q;
	logic [efsg_pkg::X_W-1:0]              x_q;
	logic [efsg_pkg::SQ_W-1:0]             sq_q;
	logic [efsg_pkg::YSQ_W-1:0]            ysq_q;
	logic [efsg_pkg::P_W-1:0]              p_q;
	logic [efsg_pkg::YTERM_W-1:0]          yterm_q;
	logic [efsg_pkg::D_W-1:0]              d_q;
	logic                                  out_valid_q;
	efsg_pkg::span_t                       out_span_q;

	logic                                  out_free;
	logic                                  cmd_pop;
	logic                                  emit;
	logic signed [efsg_pkg::COORD_W-1:0]   emit_row;
	logic                                  emit_last;
	logic                                  found;
	logic signed [efsg_pkg::START_W-1:0]   start;
	logic [efsg_pkg::X_W-1:0]              start_x;
	logic [efsg_pkg::START_W-1:0]          two_x_m1;
	logic signed [efsg_pkg::COORD_W-1:0]   cy_ext;
	logic signed [efsg_pkg::COORD_W-1:0]   cx_ext;
	logic signed [efsg_pkg::COORD_W-1:0]   y_ext;
	logic signed [efsg_pkg::COORD_W-1:0]   x_ext;

	assign out_free = !out_valid_q || span_ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			efsg_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					state_d = efsg_pkg::ST_DIAM;
				end
			end
			efsg_pkg::ST_DIAM: begin
				if (out_free) begin
					state_d = (cmd_q.h == '0) ? efsg_pkg::ST_IDLE : efsg_pkg::ST_START;
				end
			end
			efsg_pkg::ST_START:   state_d = efsg_pkg::ST_SQUARE;
			efsg_pkg::ST_SQUARE:  state_d = efsg_pkg::ST_PRODUCT;
			efsg_pkg::ST_PRODUCT: state_d = efsg_pkg::ST_SEARCH;
			efsg_pkg::ST_SEARCH: begin
				if (found) begin
					state_d = efsg_pkg::ST_UPPER;
				end
			end
			efsg_pkg::ST_UPPER: begin
				if (out_free) begin
					state_d = efsg_pkg::ST_LOWER;
				end
			end
			efsg_pkg::ST_LOWER: begin
				if (out_free) begin
					state_d = (y_q == cmd_q.h) ? efsg_pkg::ST_IDLE : efsg_pkg::ST_START;
				end
			end
		endcase
	end

	// Sequencer outputs and search arithmetic.
	always_comb begin
		cy_ext    = {{(efsg_pkg::COORD_W-efsg_pkg::CX_W){cmd_q.cy[efsg_pkg::CX_W-1]}},
			cmd_q.cy};
		cx_ext    = {{(efsg_pkg::COORD_W-efsg_pkg::CX_W){cmd_q.cx[efsg_pkg::CX_W-1]}},
			cmd_q.cx};
		y_ext     = efsg_pkg::COORD_W'(y_q);
		x_ext     = efsg_pkg::COORD_W'(cur_x_q);
		cmd_pop   = 1'b0;
		emit      = 1'b0;
		emit_row  = cy_ext;
		emit_last = 1'b0;
		// The row is settled once the ellipse test passes or the column reaches zero.
		found     = ({1'b0, p_q} + (efsg_pkg::P_W+1)'(yterm_q)
			<= (efsg_pkg::P_W+1)'(cmd_q.hhww)) || (x_q == '0);
		// Next search starts at twice the last half-span minus the one before, plus one.
		start     = signed'({1'b0, cur_x_q, 1'b0}) - signed'(efsg_pkg::START_W'(prev_x_q))
			+ efsg_pkg::START_W'(1);
		if (start[efsg_pkg::START_W-1] || start == '0) begin
			start_x = '0;
		end else begin
			start_x = start[efsg_pkg::X_W-1:0];
		end
		two_x_m1  = {x_q, 1'b0} - efsg_pkg::START_W'(1);
		unique case (state_q)
			efsg_pkg::ST_IDLE: begin
				cmd_pop = cmd_valid;
			end
			efsg_pkg::ST_DIAM: begin
				emit      = out_free;
				emit_row  = cy_ext;
				emit_last = cmd_q.h == '0;
			end
			efsg_pkg::ST_UPPER: begin
				emit     = out_free;
				emit_row = cy_ext - y_ext;
			end
			efsg_pkg::ST_LOWER: begin
				emit      = out_free;
				emit_row  = cy_ext + y_ext;
				emit_last = y_q == cmd_q.h;
			end
			efsg_pkg::ST_START, efsg_pkg::ST_SQUARE, efsg_pkg::ST_PRODUCT,
			efsg_pkg::ST_SEARCH: begin
				cmd_pop = 1'b0;
			end
		endcase
		cmd_ready = cmd_pop;
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= efsg_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (span_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Row datapath: setup multiplies, then one column step per cycle.
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q    <= cmd;
			cur_x_q  <= cmd.w;
			prev_x_q <= cmd.w;
			y_q      <= efsg_pkg::HH_W'(1);
		end
		if (emit) begin
			out_span_q.row   <= emit_row;
			out_span_q.left  <= cx_ext - x_ext;
			out_span_q.right <= cx_ext + x_ext;
			out_span_q.color <= cmd_q.color;
			out_span_q.last  <= emit_last;
		end
		unique case (state_q)
			efsg_pkg::ST_START: begin
				x_q <= start_x;
			end
			efsg_pkg::ST_SQUARE: begin
				sq_q  <= efsg_pkg::SQ_W'(x_q) * efsg_pkg::SQ_W'(x_q);
				ysq_q <= efsg_pkg::YSQ_W'(y_q) * efsg_pkg::YSQ_W'(y_q);
			end
			efsg_pkg::ST_PRODUCT: begin
				p_q     <= efsg_pkg::P_W'(sq_q) * efsg_pkg::P_W'(cmd_q.hh);
				yterm_q <= efsg_pkg::YTERM_W'(ysq_q) * efsg_pkg::YTERM_W'(cmd_q.ww);
				d_q     <= efsg_pkg::D_W'(two_x_m1) * efsg_pkg::D_W'(cmd_q.hh);
			end
			efsg_pkg::ST_SEARCH: begin
				if (found) begin
					prev_x_q <= cur_x_q;
					cur_x_q  <= x_q[efsg_pkg::HW_W-1:0];
				end else begin
					// Step one column in: x^2 h^2 drops by (2x - 1) h^2.
					x_q <= x_q - 1'b1;
					p_q <= p_q - efsg_pkg::P_W'(d_q);
					d_q <= d_q - efsg_pkg::D_W'({cmd_q.hh, 1'b0});
				end
			end
			efsg_pkg::ST_LOWER: begin
				if (emit && !emit_last) begin
					y_q <= y_q + 1'b1;
				end
			end
			efsg_pkg::ST_IDLE, efsg_pkg::ST_DIAM, efsg_pkg::ST_UPPER: begin
			end
		endcase
	end

	assign span_valid = out_valid_q;
	assign span       = out_span_q;

	`ASSERT_NEVER(a_pop_only_idle, clk, arst_n, cmd_pop && (state_q != efsg_pkg::ST_IDLE))
	`ASSERT_NEVER(a_half_span_bound, clk, arst_n, (state_q != efsg_pkg::ST_IDLE) && (cur_x_q > cmd_q.w))
	`ASSERT_AT(a_search_step, clk, arst_n, (state_q == efsg_pkg::ST_SEARCH && !found) |=> (x_q == $past(x_q) - 1'b1))
	`ASSERT_NEVER(a_emit_when_full, clk, arst_n, emit && out_valid_q && !span_ready)

endmodule
`default_nettype wire

/* hdl/ellipse_fill_span_generator.sv */
// Top level of the filled-ellipse span generator.
//
// The input stream carries one fill command per word: centre, radii and colour.
// For each command the block emits 1 + 2*h span words on the output stream:
// first the diameter row, then for each row offset the upper and the lower row.
// m_tlast marks the final span of a command.
// A command passes a two-stage front end that clamps the radii and forms the
// squared-radius products, then waits in a two-entry queue for the span engine.
// For each row the engine runs its setup states (start, square, product), then
// steps the slope search comparator one column per cycle; its work per command
// grows with h and with S, the total number of column steps (roughly h plus
// the drop in half-span between the last two rows, at most about w + h).
// Spans leave through an output register: the engine keeps working while a span
// waits and stalls only when the next span is ready and the register is full.
// New commands are taken while the engine is busy until queue and front end fill.
// Reset empties the front end, the queue and the output register at once.
`default_nettype none
module ellipse_fill_span_generator #(
	parameter int MAX_HALF_WIDTH  = 1023,
	parameter int MAX_HALF_HEIGHT = 31
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// center_x[14:0], center_y[29:15], half_width[39:30], half_height[44:40],
	// fill_color[76:45], zero fill [79:77]
	input  wire logic [79:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// row_y[15:0], span_left[31:16], span_right[47:32], span_color[79:48]
	output logic [79:0]      m_tdata,
	output logic             m_tlast
);

	efsg_pkg::req_t  req;
	efsg_pkg::cmd_t  push_data;
	efsg_pkg::cmd_t  pop_data;
	efsg_pkg::span_t span;
	logic            push_valid;
	logic            push_ready;
	logic            pop_valid;
	logic            pop_ready;

	// Unpack the command word.
	always_comb begin
		req.cx    = s_tdata[14:0];
		req.cy    = s_tdata[29:15];
		req.w     = s_tdata[39:30];
		req.h     = s_tdata[44:40];
		req.color = s_tdata[76:45];
	end

	efsg_front #(
		.MAX_HALF_WIDTH  (MAX_HALF_WIDTH),
		.MAX_HALF_HEIGHT (MAX_HALF_HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (s_tvalid),
		.req_ready  (s_tready),
		.req        (req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	efsg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	efsg_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (pop_valid),
		.cmd_ready  (pop_ready),
		.cmd        (pop_data),
		.span_valid (m_tvalid),
		.span_ready (m_tready),
		.span       (span)
	);

	// Pack the span word.
	always_comb begin
		m_tdata = {span.color, span.right, span.left, span.row};
		m_tlast = span.last;
	end

endmodule
`default_nettype wire
